### rtl/core/rss_pkg.sv
// shared types and constants of the retransmit slot scheduler
package rss_pkg;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_ACK    = 2'd1;
    localparam logic [1:0] OP_POLL   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [3:0] ST_QUEUED      = 4'd0;
    localparam logic [3:0] ST_ALREADY     = 4'd1;
    localparam logic [3:0] ST_SUB_INVALID = 4'd2;
    localparam logic [3:0] ST_FULL        = 4'd3;
    localparam logic [3:0] ST_ACKED       = 4'd4;
    localparam logic [3:0] ST_NO_MATCH    = 4'd5;
    localparam logic [3:0] ST_ACK_INVALID = 4'd6;
    localparam logic [3:0] ST_SENT        = 4'd7;
    localparam logic [3:0] ST_IDLE        = 4'd8;

    localparam logic [0:0] REG_RETRY_LIMIT = 1'd0;
    localparam logic [0:0] REG_INTERVAL    = 1'd1;

    localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd3;
    localparam logic [31:0] INTERVAL_RESET    = 32'd100000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_time;
        logic [3:0]  id_flag;
        logic [7:0]  node_id;
        logic [15:0] seq_no;
        logic [7:0]  level;
        logic [2:0]  gateway_number;
    } rss_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  slot_index;
        logic [3:0]  out_id_flag;
        logic [7:0]  out_node_id;
        logic [15:0] out_seq_no;
        logic [7:0]  out_level;
        logic [2:0]  out_gateway;
        logic [3:0]  time_slot;
        logic [7:0]  retries;
        logic        exhausted;
    } rss_out_t;

    // one table entry as stored in memory
    typedef struct packed {
        logic [7:0]  node;
        logic [15:0] seq;
        logic [3:0]  flag;
        logic [7:0]  level;
        logic [2:0]  gateway;
        logic [7:0]  retries;
        logic [31:0] due;
    } rss_entry_t;

    localparam int ENTRY_W = $bits(rss_entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_READ,
        S_WRITE
    } rss_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } rss_div_req_t;

endpackage

### rtl/core/retransmit_slot_scheduler_unit.sv
// top level of the retransmit slot scheduler
// One command word is taken when start is high and busy low; exactly one result word
// follows, shown for one cycle with done high, which the receiver must take. Each
// command scans the entry memory one slot per cycle through the registered read port.
// Submit, ack and a poll that finds nothing show their result in the cycle after the
// scan; a submit that takes a slot stays busy in a write state to write it. A poll that
// finds a due entry then runs a bit-serial division for the time slot (not waited on
// when the interval is zero) and reads and writes back the chosen entry; the result
// follows in the first idle cycle. Valid bits sit in flip-flops cleared by reset;
// entry fields live in one memory and need no clearing pass.
module retransmit_slot_scheduler_unit #(
    parameter int TX_SLOTS = 8,
    parameter int NODE_MAX = 255,
    parameter int FLAG_MAX = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rss_pkg::rss_in_t  cmd,
    output logic              busy,
    output logic              done,
    output rss_pkg::rss_out_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:2]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rss_pkg::*;

    localparam int AW = $clog2(TX_SLOTS > 1 ? TX_SLOTS : 2);
    localparam int CW = $clog2(TX_SLOTS + 1);

    // configuration
    logic [7:0]  limit_reg;
    logic [31:0] interval_reg;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= RETRY_LIMIT_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_RETRY_LIMIT)
            begin
                limit_reg <= pwdata[7:0];
            end
            else
            begin
                interval_reg <= pwdata;
            end
        end
    end
    assign prdata = (paddr[2] == REG_RETRY_LIMIT) ? {24'd0, limit_reg} : interval_reg;

    // control
    rss_state_t state_reg, state_next;
    rss_in_t    cmd_reg;
    logic [TX_SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0] scan_reg, scan_next;     // address issued
    logic          rd_vld_reg;              // read data is for slot rd_idx_reg
    logic [AW-1:0] rd_idx_reg;
    logic          hit_reg, hit_next;       // found key or best due entry
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]   best_due_reg, best_due_next;
    logic [7:0]    best_ret_reg, best_ret_next;
    logic          free_reg, free_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic [3:0]    tslot_reg, tslot_next;
    rss_out_t      res_reg, res_next;
    logic          done_reg, done_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    rss_entry_t    ram_wdata, ram_rdata;

    rss_div_req_t  div_req;
    logic          div_done;
    logic [3:0]    div_q;

    rss_ram #(.WIDTH(ENTRY_W), .DEPTH(TX_SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rss_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .done    (div_done),
        .quot_lo (div_q)
    );

    logic key_ok, rd_valid, rd_match, rd_due, rd_better, scan_end;
    logic sub_bad;
    logic [7:0] ret_inc;

    assign key_ok = ({28'd0, cmd_reg.id_flag} <= FLAG_MAX) && (cmd_reg.node_id != 8'd0)
                 && ({24'd0, cmd_reg.node_id} <= NODE_MAX);
    assign sub_bad   = cmd_reg.opcode == OP_SUBMIT && (!key_ok || cmd_reg.level == 8'd0);
    assign rd_valid  = rd_vld_reg && valid_reg[rd_idx_reg];
    assign rd_match  = rd_valid && ram_rdata.node == cmd_reg.node_id
                    && ram_rdata.seq == cmd_reg.seq_no;
    assign rd_due    = rd_valid && cmd_reg.now_time >= ram_rdata.due;
    assign rd_better = !hit_reg || ram_rdata.due < best_due_reg
                    || (ram_rdata.due == best_due_reg && ram_rdata.retries < best_ret_reg);
    assign scan_end  = (scan_reg == CW'(TX_SLOTS)) && !rd_vld_reg;
    assign ret_inc   = ram_rdata.retries + 8'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    if (cmd_reg.opcode == OP_POLL && hit_reg)
                    begin
                        state_next = S_DIV;
                    end
                    else if (cmd_reg.opcode == OP_SUBMIT && !sub_bad && !hit_reg && free_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done || interval_reg == 32'd0)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_WRITE;
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        scan_next     = scan_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        best_due_next = best_due_reg;
        best_ret_next = best_ret_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        tslot_next    = tslot_reg;
        valid_next    = valid_reg;
        res_next      = res_reg;
        done_next     = 1'b0;
        ram_raddr     = scan_reg[AW-1:0];
        ram_we        = 1'b0;
        ram_waddr     = hit_idx_reg;
        ram_wdata     = ram_rdata;
        div_req       = '{start: 1'b0, dividend: cmd_reg.now_time, divisor: interval_reg};
        case (state_reg)
            S_IDLE:
            begin
                scan_next = '0;
                hit_next  = 1'b0;
                free_next = 1'b0;
            end
            S_SCAN:
            begin
                if (scan_reg != CW'(TX_SLOTS))
                begin
                    scan_next = scan_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    if (!valid_reg[rd_idx_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (cmd_reg.opcode == OP_POLL)
                    begin
                        if (rd_due && rd_better)
                        begin
                            hit_next      = 1'b1;
                            hit_idx_next  = rd_idx_reg;
                            best_due_next = ram_rdata.due;
                            best_ret_next = ram_rdata.retries;
                        end
                    end
                    else if (rd_match && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                        res_next.out_node_id = ram_rdata.node;
                        res_next.out_seq_no  = ram_rdata.seq;
                        res_next.retries     = ram_rdata.retries;
                    end
                end
                if (scan_end)
                begin
                    res_next = '0;
                    done_next = 1'b1;
                    case (cmd_reg.opcode)
                        OP_SUBMIT:
                        begin
                            if (sub_bad)
                            begin
                                res_next.status = ST_SUB_INVALID;
                            end
                            else if (hit_reg)
                            begin
                                res_next.status     = ST_ALREADY;
                                res_next.slot_index = 3'(hit_idx_reg);
                            end
                            else if (free_reg)
                            begin
                                res_next.status     = ST_QUEUED;
                                res_next.slot_index = 3'(free_idx_reg);
                            end
                            else
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                        OP_ACK:
                        begin
                            if (!key_ok)
                            begin
                                res_next.status = ST_ACK_INVALID;
                            end
                            else if (hit_reg)
                            begin
                                res_next.status      = ST_ACKED;
                                res_next.slot_index  = 3'(hit_idx_reg);
                                res_next.out_node_id = res_reg.out_node_id;
                                res_next.out_seq_no  = res_reg.out_seq_no;
                                res_next.retries     = res_reg.retries;
                                valid_next[hit_idx_reg] = 1'b0;
                            end
                            else
                            begin
                                res_next.status = ST_NO_MATCH;
                            end
                        end
                        OP_POLL:
                        begin
                            if (hit_reg)
                            begin
                                done_next = 1'b0;
                                res_next  = res_reg;
                                div_req.start = 1'b1;
                            end
                            else
                            begin
                                res_next.status = ST_IDLE;
                            end
                        end
                        default: res_next.status = ST_IDLE;
                    endcase
                end
            end
            S_DIV:
            begin
                ram_raddr = hit_idx_reg;
                if (interval_reg == 32'd0)
                begin
                    tslot_next = 4'd0;
                end
                else if (div_done)
                begin
                    tslot_next = div_q;
                end
            end
            S_READ:
            begin
                ram_raddr = hit_idx_reg;
            end
            S_WRITE:
            begin
                if (cmd_reg.opcode == OP_POLL)
                begin
                    done_next = 1'b1;
                    ram_we    = 1'b1;
                    ram_wdata.retries = ret_inc;
                    ram_wdata.due     = cmd_reg.now_time + interval_reg;
                    res_next = '0;
                    res_next.status      = ST_SENT;
                    res_next.slot_index  = 3'(hit_idx_reg);
                    res_next.out_id_flag = ram_rdata.flag;
                    res_next.out_node_id = ram_rdata.node;
                    res_next.out_seq_no  = ram_rdata.seq;
                    res_next.out_level   = ram_rdata.level;
                    res_next.out_gateway = ram_rdata.gateway;
                    res_next.time_slot   = tslot_reg;
                    res_next.retries     = ret_inc;
                    if (ret_inc >= limit_reg)
                    begin
                        res_next.exhausted = 1'b1;
                        valid_next[hit_idx_reg] = 1'b0;
                    end
                end
                else if (cmd_reg.opcode == OP_SUBMIT)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx_reg;
                    ram_wdata = '{node: cmd_reg.node_id, seq: cmd_reg.seq_no,
                                  flag: cmd_reg.id_flag, level: cmd_reg.level,
                                  gateway: cmd_reg.gateway_number, retries: 8'd0,
                                  due: cmd_reg.now_time};
                    valid_next[free_idx_reg] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            scan_reg   <= '0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            done_reg   <= done_next;
            rd_vld_reg <= state_reg == S_SCAN && scan_reg != CW'(TX_SLOTS);
            scan_reg   <= scan_next;
            hit_reg    <= hit_next;
            free_reg   <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        rd_idx_reg   <= scan_reg[AW-1:0];
        hit_idx_reg  <= hit_idx_next;
        best_due_reg <= best_due_next;
        best_ret_reg <= best_ret_next;
        free_idx_reg <= free_idx_next;
        tslot_reg    <= tslot_next;
        res_reg      <= res_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("back to back results");
    // a queued submit shows its result while the slot is written
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE || state_reg == S_WRITE))
        else $error("result while busy");
    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && cmd_reg.opcode == OP_SUBMIT) |=> valid_reg[$past(free_idx_reg)])
        else $error("queued slot not valid");
endmodule

### rtl/core/rss_ram.sv
// generic single-port-write, one-read ram with registered read
module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/rss_div.sv
// iterative 32-bit unsigned divider giving the low four quotient bits
module rss_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rss_pkg::rss_div_req_t req,
    output logic                 done,
    output logic [3:0]           quot_lo
);
    import rss_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    // divisor zero gives quotient of all ones; caller masks that case
    assign done    = busy_reg && (cnt_reg == 6'd1);
    assign quot_lo = quo_next[3:0];
endmodule
